// File: hdl/lsvd_pkg.sv
// Shared constants, codes and result type of the LIFO stack with delete-by-value.
package lsvd_pkg;

	// Stack geometry.
	localparam int DEPTH  = 16;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Beat field widths.
	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// One result beat.
	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] data_out;
		logic [OCC_W-1:0]         occupancy;
	} res_t;

endpackage

// File: hdl/lsvd_if.sv
// Request and response channel interfaces of the LIFO stack.
interface lsvd_req_if import lsvd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] data_in;

	modport source(output valid, output operation, output data_in, input ready);
	modport sink(input valid, input operation, input data_in, output ready);
endinterface

interface lsvd_rsp_if import lsvd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] data_out;
	logic [OCC_W-1:0]         occupancy;

	modport source(output valid, output status, output data_out, output occupancy,
		input ready);
	modport sink(input valid, input status, input data_out, input occupancy,
		output ready);
endinterface

// File: hdl/lifo_stack_with_value_delete.sv
// Top level of the LIFO stack with delete-by-value: sequencer plus output register.
//
// A bounded stack of DEPTH signed 32-bit words held in one synchronous memory. Each
// request beat is a push, a pop or a delete of the topmost entry equal to the given
// value; each produces exactly one response beat with a status, the popped word and
// the occupancy afterwards. A push and an unused operation code finish in the cycle
// they are accepted, a pop waits for the memory read, and a delete issues the first
// read in the cycle it is accepted, then scans from the top down to the match and
// moves each entry above the match down one place; its pace is set by the single
// memory read port, which serves one entry a cycle.
// The result is then carried into the output register, and the sequencer takes
// the next request as soon as the previous result has moved there, even while the
// response beat still waits for the consumer.
module lifo_stack_with_value_delete import lsvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lsvd_req_if.sink   req,
	lsvd_rsp_if.source rsp
);

	logic res_valid;
	res_t res;
	logic res_take;
	logic out_valid_q;
	res_t out_q;

	lsvd_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	// The output register loads a finished result whenever it is empty or draining.
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	// Response beat.
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_q.status;
	assign rsp.data_out  = out_q.data_out;
	assign rsp.occupancy = out_q.occupancy;

endmodule

// File: hdl/lsvd_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module lsvd_ram #(
	parameter int DW = 32,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [(1 << AW)];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/lsvd_engine.sv
// Sequencer that runs push, pop and delete-by-value against the stack memory.
module lsvd_engine import lsvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lsvd_req_if.sink   req,
	output logic       res_valid,
	output res_t       res,
	input  logic       res_take
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POP   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]               state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic signed [DATA_W-1:0] word_q, word_d;
	logic [ADDR_W-1:0]        addr_s1, addr_d;
	res_t                     res_q, res_d;

	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [DATA_W-1:0]        wdata;
	logic                     re;
	logic [ADDR_W-1:0]        raddr;
	logic [DATA_W-1:0]        rdata;
	logic [ADDR_W-1:0]        top_addr;

	lsvd_ram #(
		.DW(DATA_W),
		.AW(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign top_addr  = ADDR_W'(cnt_q - CNT_W'(1));
	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Next-state logic. The scan walks down from the top one entry per cycle, comparing
	// the word read last cycle while issuing the next read; the shift then moves each
	// entry above the match down one place, reading one entry while writing the previous.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		word_d  = word_q;
		addr_d  = addr_s1;
		res_d   = res_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = word_q;
		re      = 1'b0;
		raddr   = '0;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					word_d         = req.data_in;
					res_d.data_out = '0;
					res_d.status   = ST_DONE;
					state_d        = S_DONE;
					case (req.operation)
						OP_PUSH: begin
							if (cnt_q == CNT_W'(DEPTH)) begin
								res_d.status = ST_FULL;
							end else begin
								we    = 1'b1;
								waddr = ADDR_W'(cnt_q);
								wdata = req.data_in;
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						OP_POP: begin
							if (cnt_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = top_addr;
								state_d = S_POP;
							end
						end
						OP_DELETE: begin
							if (cnt_q == '0) begin
								res_d.status = ST_NOT_FOUND;
							end else begin
								re      = 1'b1;
								raddr   = top_addr;
								addr_d  = top_addr;
								state_d = S_SCAN;
							end
						end
						default: begin
							res_d.status = ST_DONE;
						end
					endcase
				end
			end
			S_POP: begin
				res_d.data_out = rdata;
				cnt_d          = cnt_q - CNT_W'(1);
				state_d        = S_DONE;
			end
			S_SCAN: begin
				if (rdata == word_q) begin
					if (addr_s1 == top_addr) begin
						cnt_d   = cnt_q - CNT_W'(1);
						state_d = S_DONE;
					end else begin
						re      = 1'b1;
						raddr   = addr_s1 + ADDR_W'(1);
						addr_d  = addr_s1 + ADDR_W'(1);
						state_d = S_SHIFT;
					end
				end else if (addr_s1 == '0) begin
					res_d.status = ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					re     = 1'b1;
					raddr  = addr_s1 - ADDR_W'(1);
					addr_d = addr_s1 - ADDR_W'(1);
				end
			end
			S_SHIFT: begin
				we    = 1'b1;
				waddr = addr_s1 - ADDR_W'(1);
				wdata = rdata;
				if (addr_s1 == top_addr) begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = S_DONE;
				end else begin
					re     = 1'b1;
					raddr  = addr_s1 + ADDR_W'(1);
					addr_d = addr_s1 + ADDR_W'(1);
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Occupancy is sampled when the result is finished.
		if (state_d == S_DONE && state_q != S_DONE) begin
			res_d.occupancy = OCC_W'(cnt_d);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		word_q  <= word_d;
		addr_s1 <= addr_d;
		res_q   <= res_d;
	end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the LIFO stack with delete-by-value.
module tb_top;
	import lsvd_pkg::*;

	// The operation code that the block ignores.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Run limits in clock cycles, and the clock period.
	localparam int RX_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES   = 100;
	localparam int LIMIT_CYCLES   = 300000;
	localparam int CLK_PERIOD     = 20;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] word;
		bit                       drain;
	} req_item_t;

	logic clk;
	logic arst_n;

	lsvd_req_if req_ch ();
	lsvd_rsp_if rsp_ch ();

	lifo_stack_with_value_delete uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Requests waiting to be offered, and responses the stack model predicts.
	req_item_t req_pending[$];
	res_t      rsp_expected[$];

	// Shadow copy of the stack contents.
	logic signed [DATA_W-1:0] model_stack[DEPTH];
	int                       model_count = 0;

	int  req_offered  = 0;
	int  req_accepted = 0;
	int  mismatches   = 0;
	int  hold_left    = 0;
	bit  hold_done    = 1'b0;
	bit  calm;

	// No random idling on either side while this window of requests goes through.
	assign calm = (req_accepted >= 150) && (req_accepted < 260);

	// Apply one request to the shadow stack and return the response it should give.
	function automatic res_t stack_apply(input logic [OP_W-1:0] op,
		input logic signed [DATA_W-1:0] word);
		res_t r;
		int   hit;
		r.status   = ST_DONE;
		r.data_out = '0;
		case (op)
			OP_PUSH: begin
				if (model_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_stack[model_count] = word;
					model_count++;
				end
			end
			OP_POP: begin
				if (model_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					model_count--;
					r.data_out = model_stack[model_count];
				end
			end
			OP_DELETE: begin
				// Find the topmost match, then close the gap above it.
				hit = -1;
				for (int i = model_count - 1; i >= 0; i--) begin
					if (hit < 0 && model_stack[i] == word) begin
						hit = i;
					end
				end
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int j = hit; j < model_count - 1; j++) begin
						model_stack[j] = model_stack[j + 1];
					end
					model_count--;
				end
			end
			default: begin
			end
		endcase
		r.occupancy = model_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic queue_req(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] word,
		input bit drain);
		req_item_t it;
		it.op    = op;
		it.word  = word;
		it.drain = drain;
		req_pending.push_back(it);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Request driver: a new beat goes out once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_accepted != req_offered) begin
				// Hold the current beat until it is accepted.
			end else if (req_pending.size() == 0
				|| (req_pending[0].drain && rsp_expected.size() != 0)
				|| (!calm && $urandom_range(99) < 22)) begin
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid     <= 1'b1;
				req_ch.operation <= req_pending[0].op;
				req_ch.data_in   <= req_pending[0].word;
				req_pending.pop_front();
				req_offered++;
			end
		end
	end

	// Response ready, with one long hold-off so the block backs up into its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && req_accepted >= 60) begin
				hold_done = 1'b1;
				hold_left = RX_HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 22);
			end
		end
	end

	// Monitor: check each response beat, then predict from each accepted request beat.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status    = rsp_ch.status;
				got.data_out  = rsp_ch.data_out;
				got.occupancy = rsp_ch.occupancy;
				if (rsp_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected response beat: status %0d data_out %0d occupancy %0d",
							got.status, got.data_out, got.occupancy);
					end
				end else begin
					want = rsp_expected.pop_front();
					if (got.status !== want.status || got.data_out !== want.data_out
						|| got.occupancy !== want.occupancy) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("response mismatch: expected status %0d data_out %0d occupancy %0d, got status %0d data_out %0d occupancy %0d",
								want.status, want.data_out, want.occupancy,
								got.status, got.data_out, got.occupancy);
						end
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				rsp_expected.push_back(stack_apply(req_ch.operation, req_ch.data_in));
				req_accepted++;
			end
		end
	end

	// Watchdog.
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("lifo_stack_with_value_delete: mismatch");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		logic signed [DATA_W-1:0] pool[8];
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] word;
		int                       push_pct;
		int                       roll;

		req_ch.valid     = 1'b0;
		req_ch.operation = OP_PUSH;
		req_ch.data_in   = '0;
		rsp_ch.ready     = 1'b0;
		arst_n           = 1'b0;

		// Directed: empty-stack refusals and the ignored code.
		queue_req(OP_POP, 32'sd0, 1'b0);
		queue_req(OP_DELETE, 32'sd7, 1'b0);
		queue_req(OP_UNUSED, -32'sd1, 1'b0);
		// Extremes, with a duplicate of the largest value on top.
		queue_req(OP_PUSH, 32'sh7fffffff, 1'b0);
		queue_req(OP_PUSH, 32'sh80000000, 1'b0);
		queue_req(OP_PUSH, 32'sd0, 1'b0);
		queue_req(OP_PUSH, -32'sd1, 1'b0);
		queue_req(OP_PUSH, 32'sh7fffffff, 1'b0);
		// Delete the top one of two copies, then one in the middle, then a miss.
		queue_req(OP_DELETE, 32'sh7fffffff, 1'b0);
		queue_req(OP_DELETE, 32'sh80000000, 1'b0);
		queue_req(OP_DELETE, 32'sd12345, 1'b0);
		queue_req(OP_POP, 32'sd0, 1'b0);
		// Fill to the limit, push once more, then delete the bottom entry of a full stack.
		for (int k = 0; k < DEPTH - 2; k++) begin
			queue_req(OP_PUSH, $signed($urandom()), 1'b0);
		end
		queue_req(OP_PUSH, 32'sd42, 1'b0);
		queue_req(OP_DELETE, 32'sh7fffffff, 1'b1);

		// Random: phases leaning toward pushes or pops, values mostly from a small pool.
		pool[0] = 32'sh7fffffff;
		pool[1] = 32'sh80000000;
		pool[2] = 32'sd0;
		pool[3] = -32'sd1;
		for (int k = 4; k < 8; k++) begin
			pool[k] = $signed($urandom());
		end
		for (int blk = 0; blk < 20; blk++) begin
			push_pct = $urandom_range(80, 20);
			for (int k = 0; k < 20; k++) begin
				roll = $urandom_range(99);
				if (roll < 3) begin
					op = OP_UNUSED;
				end else begin
					roll = $urandom_range(99);
					if (roll < push_pct) begin
						op = OP_PUSH;
					end else if (roll < push_pct + (100 - push_pct) / 2) begin
						op = OP_POP;
					end else begin
						op = OP_DELETE;
					end
				end
				if ($urandom_range(99) < 60) begin
					word = pool[$urandom_range(7)];
				end else begin
					word = $signed($urandom());
				end
				queue_req(op, word, (blk == 12 && k == 0) || $urandom_range(99) == 0);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all requests to go in and all responses to come back.
		while (req_pending.size() != 0 || req_accepted != req_offered
			|| rsp_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && rsp_expected.size() == 0) begin
			$display("lifo_stack_with_value_delete: match");
		end else begin
			$display("lifo_stack_with_value_delete: mismatch");
		end
		$finish;
	end

endmodule
